### rtl/ranb_pkg.sv
// ----------------------------------------------------------------------------
// ranb_pkg
// Types and constants of the row-aligned nonzero balancer.
// ----------------------------------------------------------------------------
package ranb_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned PART_W   = 8;
   localparam int unsigned PCNT_W   = 9;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes of the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_PART_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_NNZ  = 2'd1;

   localparam logic [WORD_W-1:0] SAT_MAX = {WORD_W{1'b1}};

   // one result record
   typedef struct packed {
      logic                run_end;
      logic                unsorted_error;
      logic [WORD_W-1:0]   part_nonzeros;
      logic [WORD_W-1:0]   part_rows;
      logic [WORD_W-1:0]   part_start;
      logic [PART_W-1:0]   part_index;
   } rec_type;

   function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W] ? SAT_MAX : s[WORD_W-1:0];
   endfunction

endpackage

### rtl/row_aligned_nnz_balancer.sv
// ----------------------------------------------------------------------------
// row_aligned_nnz_balancer
// Greedy split of a row-sorted nonzero stream into row-aligned parts.
// ----------------------------------------------------------------------------
// an item is held in the input register, then its records enter the rsp_ queue
// throughput: one item per cycle, limited by a 4-entry record queue that
//    needs room for the two records one item can produce
// a listed csr write starts a bit-serial quotient; req_ and csr_ stall meanwhile
// reset: synchronous, active high; part_count 1, total_nnz 0, quota 0, run idle
module row_aligned_nnz_balancer
   import ranb_pkg::*;
#(
   parameter int unsigned MAX_PARTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] row_index
   input  logic                  req_tlast,   // is_final
   // result records
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [103:0]          rsp_tdata,   // [7:0] part_index, [39:8] part_start,
                                              // [71:40] part_rows, [103:72] part_nonzeros
   output logic [0:0]            rsp_tuser,   // [0] unsorted_error
   output logic                  rsp_tlast,   // run_end
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata
);

   // effective part limit: min(MAX_PARTS, 256)
   localparam int unsigned LIM_INT = (MAX_PARTS < 256) ? MAX_PARTS : 256;
   localparam logic [PCNT_W-1:0] PART_LIMIT = PCNT_W'(LIM_INT);
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned DIV_STEPS = WORD_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // ---------------------------------------------------------------------
   // configuration registers and the quotient unit
   // ---------------------------------------------------------------------
   logic [PCNT_W-1:0]     part_count_ff, part_count_in;
   logic [WORD_W-1:0]     total_nnz_ff, total_nnz_in;
   logic [WORD_W-1:0]     quota_ff, quota_in;
   logic                  div_busy_ff, div_busy_in;
   logic [WORD_W-1:0]     div_num_ff, div_num_in;   // dividend, quotient shifts in
   logic [PCNT_W-1:0]     div_den_ff, div_den_in;
   logic [PCNT_W-1:0]     div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   logic                  csr_xfer;
   logic                  csr_hit;
   logic [PCNT_W-1:0]     eff_parts;      // clamped count of the live register
   logic [PCNT_W-1:0]     new_eff;        // clamped count after this write
   logic [PCNT_W-1:0]     new_pcount;
   logic [PCNT_W:0]       div_trial;

   function automatic logic [PCNT_W-1:0] clamp_parts(input logic [PCNT_W-1:0] n);
      logic [PCNT_W-1:0] r;
      r = n;
      if (r == '0) r = PCNT_W'(1);
      if (r > PART_LIMIT) r = PART_LIMIT;
      return r;
   endfunction

   assign csr_ready = !div_busy_ff;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_hit   = csr_xfer &&
                      ((csr_index == CSR_PART_COUNT) || (csr_index == CSR_TOTAL_NNZ));
   assign eff_parts = clamp_parts(part_count_ff);

   always_comb begin
      part_count_in = part_count_ff;
      total_nnz_in  = total_nnz_ff;
      quota_in      = quota_ff;
      div_busy_in   = div_busy_ff;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      new_pcount    = part_count_ff;
      new_eff       = eff_parts;
      div_trial     = {div_rem_ff, div_num_ff[WORD_W-1]};

      if (csr_hit) begin
         if (csr_index == CSR_PART_COUNT) begin
            new_pcount    = csr_wdata[PCNT_W-1:0];
            part_count_in = new_pcount;
            div_num_in    = total_nnz_ff;
         end else begin
            total_nnz_in  = csr_wdata;
            div_num_in    = csr_wdata;
         end
         new_eff     = clamp_parts(new_pcount);
         div_den_in  = new_eff;
         div_rem_in  = '0;
         div_cnt_in  = '0;
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         // one restoring step per cycle
         if (div_trial >= {1'b0, div_den_ff}) begin
            div_rem_in = PCNT_W'(div_trial - {1'b0, div_den_ff});
            div_num_in = {div_num_ff[WORD_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_trial[PCNT_W-1:0];
            div_num_in = {div_num_ff[WORD_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            div_busy_in = 1'b0;
            quota_in    = div_num_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   logic               in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]  in_row_ff, in_row_in;
   logic               in_fin_ff, in_fin_in;
   logic               req_xfer;
   logic               consume;

   logic [Q_PTR_W:0]   q_count_ff, q_count_in;

   // process the held item when the queue can take two records
   assign consume    = in_valid_ff && (q_count_ff <= (Q_PTR_W+1)'(Q_DEPTH - 2));
   assign req_tready = !div_busy_ff && (!in_valid_ff || consume);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_row_in   = in_row_ff;
      in_fin_in   = in_fin_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_row_in   = req_tdata;
         in_fin_in   = req_tlast;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // partition state and record generation
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0]  prev_row_ff, prev_row_in;
   logic [PART_W-1:0]  cur_part_ff, cur_part_in;
   logic [WORD_W-1:0]  nnz_ff, nnz_in;
   logic [WORD_W-1:0]  rows_ff, rows_in;
   logic [WORD_W-1:0]  offset_ff, offset_in;
   logic               awaiting_ff, awaiting_in;
   logic               aborted_ff, aborted_in;

   rec_type            rec [2];
   logic [1:0]         rec_n;
   logic [PCNT_W-1:0]  last_part;
   logic               went_down;

   assign last_part = eff_parts - PCNT_W'(1);

   always_comb begin
      prev_row_in = prev_row_ff;
      cur_part_in = cur_part_ff;
      nnz_in      = nnz_ff;
      rows_in     = rows_ff;
      offset_in   = offset_ff;
      awaiting_in = awaiting_ff;
      aborted_in  = aborted_ff;
      rec[0]      = '0;
      rec[1]      = '0;
      rec_n       = 2'd0;
      went_down   = 1'b0;

      if (consume) begin
         if (aborted_ff) begin
            // drop items until the final one re-arms the run
            if (in_fin_ff) begin
               aborted_in = 1'b0;
            end
         end else begin
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               cur_part_in = '0;
               offset_in   = '0;
               rows_in     = WORD_W'(1);
               nnz_in      = WORD_W'(1);
            end else if (in_row_ff == prev_row_ff) begin
               nnz_in = sat_add(nnz_ff, WORD_W'(1));
            end else if (in_row_ff > prev_row_ff) begin
               if ((nnz_ff < quota_ff) || ({1'b0, cur_part_ff} >= last_part)) begin
                  nnz_in  = sat_add(nnz_ff, WORD_W'(1));
                  rows_in = sat_add(rows_ff, WORD_W'(1));
               end else begin
                  // quota met at a row boundary: close the part
                  rec[0].part_index    = cur_part_ff;
                  rec[0].part_start    = offset_ff;
                  rec[0].part_rows     = rows_ff;
                  rec[0].part_nonzeros = nnz_ff;
                  rec_n                = 2'd1;
                  offset_in   = sat_add(offset_ff, nnz_ff);
                  cur_part_in = cur_part_ff + PART_W'(1);
                  rows_in     = WORD_W'(1);
                  nnz_in      = WORD_W'(1);
               end
            end else begin
               // row index went down: error record, then abort unless final
               went_down             = 1'b1;
               rec[0]                = '0;
               rec[0].unsorted_error = 1'b1;
               rec[0].run_end        = in_fin_ff;
               rec_n                 = 2'd1;
               aborted_in            = !in_fin_ff;
            end

            if (!went_down) begin
               prev_row_in = in_row_ff;
               if (in_fin_ff) begin
                  rec[rec_n[0]].part_index    = cur_part_in;
                  rec[rec_n[0]].part_start    = offset_in;
                  rec[rec_n[0]].part_rows     = rows_in;
                  rec[rec_n[0]].part_nonzeros = nnz_in;
                  rec[rec_n[0]].run_end       = 1'b1;
                  rec_n                       = rec_n + 2'd1;
               end
            end
         end

         // end of run (normal, or error on the final item, or final while aborted)
         if (in_fin_ff) begin
            prev_row_in = '0;
            cur_part_in = '0;
            nnz_in      = '0;
            rows_in     = '0;
            offset_in   = '0;
            awaiting_in = 1'b1;
            aborted_in  = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // record queue feeding rsp_
   // ---------------------------------------------------------------------
   rec_type               q_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]    q_head_ff, q_head_in;
   logic [Q_PTR_W-1:0]    q_tail_ff, q_tail_in;
   logic                  rsp_xfer;
   rec_type               q_out;

   assign q_out      = q_mem[q_head_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {q_out.part_nonzeros, q_out.part_rows, q_out.part_start,
                        q_out.part_index};
   assign rsp_tuser  = q_out.unsorted_error;
   assign rsp_tlast  = q_out.run_end;

   always_comb begin
      q_head_in  = q_head_ff + Q_PTR_W'(rsp_xfer);
      q_tail_in  = q_tail_ff + Q_PTR_W'(rec_n);
      q_count_in = q_count_ff + (Q_PTR_W+1)'(rec_n) - (Q_PTR_W+1)'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (rec_n != 2'd0) begin
         q_mem[q_tail_ff] <= rec[0];
      end
      if (rec_n == 2'd2) begin
         q_mem[q_tail_ff + Q_PTR_W'(1)] <= rec[1];
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         part_count_ff <= PCNT_W'(1);
         total_nnz_ff  <= '0;
         quota_ff      <= '0;
         div_busy_ff   <= 1'b0;
         in_valid_ff   <= 1'b0;
         prev_row_ff   <= '0;
         cur_part_ff   <= '0;
         nnz_ff        <= '0;
         rows_ff       <= '0;
         offset_ff     <= '0;
         awaiting_ff   <= 1'b1;
         aborted_ff    <= 1'b0;
         q_head_ff     <= '0;
         q_tail_ff     <= '0;
         q_count_ff    <= '0;
      end else begin
         part_count_ff <= part_count_in;
         total_nnz_ff  <= total_nnz_in;
         quota_ff      <= quota_in;
         div_busy_ff   <= div_busy_in;
         in_valid_ff   <= in_valid_in;
         prev_row_ff   <= prev_row_in;
         cur_part_ff   <= cur_part_in;
         nnz_ff        <= nnz_in;
         rows_ff       <= rows_in;
         offset_ff     <= offset_in;
         awaiting_ff   <= awaiting_in;
         aborted_ff    <= aborted_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         q_count_ff    <= q_count_in;
      end
   end

   // payload of the input stage and the quotient datapath
   always_ff @(posedge clock) begin
      in_row_ff  <= in_row_in;
      in_fin_ff  <= in_fin_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= (Q_PTR_W+1)'(Q_DEPTH))
      else $error("record queue overflow");

   a_no_item_while_div: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !req_xfer)
      else $error("input taken while quota is being computed");

   a_abort_not_armed: assert property (@(posedge clock) disable iff (reset)
      !(aborted_ff && awaiting_ff))
      else $error("aborted run marked as awaiting first item");

   a_error_aborts: assert property (@(posedge clock) disable iff (reset)
      (went_down && consume && !in_fin_ff) |=> aborted_ff)
      else $error("decreasing row did not abort the run");

   a_final_rearms: assert property (@(posedge clock) disable iff (reset)
      (consume && in_fin_ff) |=> (awaiting_ff && !aborted_ff && (nnz_ff == '0)))
      else $error("final item did not re-arm the run");

endmodule

### tb/row_aligned_nnz_balancer_tb.sv
// ----------------------------------------------------------------------------
// row_aligned_nnz_balancer_tb
// Drives row-sorted nonzero streams through the balancer and checks every
// part record against a cycle-free model of the greedy row-aligned split.
// A directed table covers reset values, field extremes, the unsorted abort
// and part count clamping. Random sorted runs with bursty input, receiver
// stalls and register changes between phases follow.
// ----------------------------------------------------------------------------
module row_aligned_nnz_balancer_tb
   import ranb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TB_MAX_PARTS   = 256;
   localparam int unsigned PART_LIMIT     = (TB_MAX_PARTS < 256) ? TB_MAX_PARTS : 256;
   localparam int unsigned ITEM_TARGET    = 1400;
   localparam int unsigned SETTLE_CYCLES  = 8;      // slack after the owed records drain
   localparam int unsigned LONG_STALL     = 200;    // receiver hold-off, in cycles
   localparam int unsigned PRESSURE_PHASE = 3;
   localparam int unsigned LIMIT_CYCLES   = 400000;

   // register indexes past the end of the list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE0 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE1 = 2'd3;

   localparam rec_type NO_REC = '0;

   typedef enum logic [0:0] {DIR_ITEM, DIR_CSR} dir_op_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_MOSTLY} rx_mode_type;

   // one row of the directed table; rec is only used when typed is set
   typedef struct packed {
      dir_op_type            op;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [31:0]           value;     // row index or register data
      logic                  fin;
      logic                  typed;
      rec_type               rec;
   } dir_row_type;

   localparam int DIR_ROWS = 33;

   // rec fields in order: run_end, unsorted_error, nonzeros, rows, start, index
   dir_row_type dir_table [DIR_ROWS] = '{
      // out of reset: one part, quota 0, single-item runs
      '{DIR_ITEM, '0, 32'd5,          1'b1, 1'b1, '{1'b1, 1'b0, 32'd1, 32'd1, 32'd0, 8'd0}},
      '{DIR_ITEM, '0, 32'hFFFF_FFFF,  1'b1, 1'b1, '{1'b1, 1'b0, 32'd1, 32'd1, 32'd0, 8'd0}},
      // four parts, quota 2: a short run that splits twice
      '{DIR_CSR,  CSR_PART_COUNT, 32'd4, 1'b0, 1'b0, NO_REC},
      '{DIR_CSR,  CSR_TOTAL_NNZ,  32'd8, 1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd0,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd0,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd1,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd1,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd2,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd3,          1'b1, 1'b0, NO_REC},
      // decreasing index mid-run, the rest is swallowed up to the final item
      '{DIR_ITEM, '0, 32'hFFFF_FFFF,  1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd0,          1'b0, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 8'd0}},
      '{DIR_ITEM, '0, 32'hA5A5_A5A5,  1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd7,          1'b1, 1'b0, NO_REC},
      // decreasing index on the final item itself
      '{DIR_ITEM, '0, 32'd10,         1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd3,          1'b1, 1'b1, '{1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 8'd0}},
      // writes beyond the register list
      '{DIR_CSR,  CSR_IDX_SPARE0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_REC},
      '{DIR_CSR,  CSR_IDX_SPARE1, 32'h5A5A_5A5A, 1'b0, 1'b0, NO_REC},
      // part count zero acts as one, so the only part never closes
      '{DIR_CSR,  CSR_PART_COUNT, 32'd0, 1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd1,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd2,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd3,          1'b1, 1'b1, '{1'b1, 1'b0, 32'd3, 32'd3, 32'd0, 8'd0}},
      // part count clamped to the limit, huge total
      '{DIR_CSR,  CSR_PART_COUNT, 32'h0000_01FF, 1'b0, 1'b0, NO_REC},
      '{DIR_CSR,  CSR_TOTAL_NNZ,  32'hFFFF_FFFF, 1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd4,          1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd9,          1'b1, 1'b1, '{1'b1, 1'b0, 32'd2, 32'd2, 32'd0, 8'd0}},
      // quota 0: every new row cuts, then the part count drops mid-run
      '{DIR_CSR,  CSR_TOTAL_NNZ,  32'd0, 1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd50,         1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd51,         1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd52,         1'b0, 1'b0, NO_REC},
      '{DIR_CSR,  CSR_PART_COUNT, 32'd2, 1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd53,         1'b0, 1'b0, NO_REC},
      '{DIR_ITEM, '0, 32'd54,         1'b1, 1'b0, NO_REC}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [103:0]          rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [31:0]           csr_wdata;

   // typed expectation riding along with the current input transfer
   logic                  req_typed;
   rec_type               req_exp;

   // model of the split: registers and run state
   logic [8:0]            cfg_parts  = 9'd1;
   logic [31:0]           cfg_total  = '0;
   logic [31:0]           nz_quota   = '0;
   logic [31:0]           row_last   = '0;
   logic [7:0]            part_no    = '0;
   logic [31:0]           part_nz    = '0;
   logic [31:0]           part_rw    = '0;
   logic [31:0]           part_base  = '0;
   logic                  run_idle   = 1'b1;
   logic                  run_dead   = 1'b0;

   rec_type               owed_parts [$];   // part records still to come out

   int unsigned           mismatches     = 0;
   int unsigned           items_in       = 0;
   int unsigned           useful_items   = 0;
   int unsigned           parts_checked  = 0;
   int unsigned           abort_records  = 0;
   int unsigned           run_ends       = 0;
   int unsigned           reg_writes     = 0;
   int unsigned           phases         = 0;
   int unsigned           stall_asks     = 0;
   int unsigned           stall_done     = 0;
   int unsigned           cycle_count    = 0;
   int unsigned           burst_left     = 0;
   bit                    steady_send    = 1'b0;
   bit                    run_open       = 1'b0;
   logic [31:0]           walk_row       = '0;

   always #4 clock = ~clock;

   row_aligned_nnz_balancer #(
      .MAX_PARTS (TB_MAX_PARTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------- model

   function automatic logic [31:0] parts_in_use(input logic [8:0] n);
      if (n == 0) return 32'd1;
      if (n > PART_LIMIT) return PART_LIMIT;
      return 32'(n);
   endfunction

   // counters stick at all ones instead of wrapping
   function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
      return (a > ~b) ? '1 : a + b;
   endfunction

   function automatic rec_type part_rec(input logic [7:0] idx, input logic [31:0] start,
                                        input logic [31:0] rows, input logic [31:0] nnz,
                                        input logic err, input logic last);
      rec_type r;
      r.part_index     = idx;
      r.part_start     = start;
      r.part_rows      = rows;
      r.part_nonzeros  = nnz;
      r.unsorted_error = err;
      r.run_end        = last;
      return r;
   endfunction

   task automatic restart_run();
      row_last  = '0;
      part_no   = '0;
      part_nz   = '0;
      part_rw   = '0;
      part_base = '0;
      run_idle  = 1'b1;
      run_dead  = 1'b0;
   endtask

   // one nonzero into the greedy split; up to two records come out
   task automatic split_step(input logic [31:0] row, input logic fin,
                             output rec_type r0, output rec_type r1, output int n);
      rec_type tail;
      n  = 0;
      r0 = NO_REC;
      r1 = NO_REC;
      if (run_dead) begin
         // swallowing the rest of an unsorted stream
         if (fin) restart_run();
         return;
      end
      if (run_idle) begin
         run_idle  = 1'b0;
         part_no   = '0;
         part_base = '0;
         part_rw   = 32'd1;
         part_nz   = 32'd1;
      end else if (row == row_last) begin
         part_nz = add_clamped(part_nz, 32'd1);
      end else if (row > row_last) begin
         // new row: cut only when the part is full and not the last one
         if (part_nz < nz_quota || 32'(part_no) >= parts_in_use(cfg_parts) - 32'd1) begin
            part_nz = add_clamped(part_nz, 32'd1);
            part_rw = add_clamped(part_rw, 32'd1);
         end else begin
            r0        = part_rec(part_no, part_base, part_rw, part_nz, 1'b0, 1'b0);
            n         = 1;
            part_base = add_clamped(part_base, part_nz);
            part_no   = part_no + 8'd1;
            part_rw   = 32'd1;
            part_nz   = 32'd1;
         end
      end else begin
         // decreasing row: one error record, then abort unless final
         r0 = part_rec('0, '0, '0, '0, 1'b1, fin);
         n  = 1;
         if (fin) restart_run();
         else run_dead = 1'b1;
         return;
      end
      row_last = row;
      if (fin) begin
         tail = part_rec(part_no, part_base, part_rw, part_nz, 1'b0, 1'b1);
         if (n == 0) r0 = tail;
         else r1 = tail;
         n++;
         restart_run();
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      mismatches++;
      if (mismatches <= 40)
         $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
                  $realtime, what, got_v, want_v);
   endtask

   always @(posedge clock) begin : scoreboard
      rec_type got, want, r0, r1;
      int      n;
      if (!reset) begin
         // result transfer against the oldest owed record
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tuser[0], rsp_tdata};
            if (owed_parts.size() == 0) begin
               report_mismatch("record with nothing owed, part_index", 32'(got.part_index), '0);
            end else begin
               want = owed_parts.pop_front();
               parts_checked++;
               if (want.unsorted_error) abort_records++;
               if (want.run_end) run_ends++;
               if (got.part_index != want.part_index)
                  report_mismatch("part_index", 32'(got.part_index), 32'(want.part_index));
               if (got.part_start != want.part_start)
                  report_mismatch("part_start", got.part_start, want.part_start);
               if (got.part_rows != want.part_rows)
                  report_mismatch("part_rows", got.part_rows, want.part_rows);
               if (got.part_nonzeros != want.part_nonzeros)
                  report_mismatch("part_nonzeros", got.part_nonzeros, want.part_nonzeros);
               if (got.unsorted_error != want.unsorted_error)
                  report_mismatch("unsorted_error", 32'(got.unsorted_error),
                                  32'(want.unsorted_error));
               if (got.run_end != want.run_end)
                  report_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
            end
         end
         // input transfer: model always advances, a typed row overrides its output
         if (req_tvalid && req_tready) begin
            items_in++;
            split_step(req_tdata, req_tlast, r0, r1, n);
            if (req_typed) begin
               owed_parts.push_back(req_exp);
            end else begin
               if (n > 0) owed_parts.push_back(r0);
               if (n > 1) owed_parts.push_back(r1);
            end
         end
         // register write: quota follows any write to a listed register
         if (csr_valid && csr_ready) begin
            reg_writes++;
            if (csr_index == CSR_PART_COUNT || csr_index == CSR_TOTAL_NNZ) begin
               if (csr_index == CSR_PART_COUNT) cfg_parts = csr_wdata[8:0];
               else cfg_total = csr_wdata;
               nz_quota = cfg_total / parts_in_use(cfg_parts);
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // one item in a burst; a gap of random length opens each new burst unless steady
   task automatic send_item(input logic [31:0] row, input logic fin,
                            input logic typed, input rec_type rec);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = steady_send ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= row;
      req_tlast  <= fin;
      req_typed  <= typed;
      req_exp    <= rec;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending, let every owed record drain, then let the pipe settle
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_parts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one sorted run with random repeats and jumps; broken runs step back once
   task automatic play_run(input int len, input bit closed, input bit broken);
      int          bad_at;
      int          k;
      int          pick;
      logic [31:0] stride;
      logic [31:0] drop;
      logic [31:0] prev_sent;
      bad_at    = broken ? $urandom_range(1, len - 1) : -1;
      prev_sent = '0;
      if (!run_open) begin
         pick = $urandom_range(0, 2);
         if (pick == 0) walk_row = $urandom_range(0, 200);
         else if (pick == 1) walk_row = $urandom;
         else walk_row = 32'hFFFF_FFFF - $urandom_range(0, 300);
      end
      run_open = !closed;
      for (k = 0; k < len; k++) begin
         if (k == bad_at && prev_sent != 0) begin
            // step below the row sent last
            drop = (prev_sent > 1000) ? $urandom_range(1, 1000)
                                      : $urandom_range(1, prev_sent);
            send_item(prev_sent - drop, k == len - 1, 1'b0, NO_REC);
            useful_items++;
            if (k != len - 1) begin
               // junk the block has to ignore, then the final item re-arms it
               repeat ($urandom_range(0, 4)) send_item($urandom, 1'b0, 1'b0, NO_REC);
               send_item($urandom, 1'b1, 1'b0, NO_REC);
            end
            return;
         end
         send_item(walk_row, closed && k == len - 1, 1'b0, NO_REC);
         useful_items++;
         prev_sent = walk_row;
         pick = $urandom_range(0, 9);
         if (pick < 5) stride = '0;
         else if (pick == 9) stride = $urandom_range(4, 100000);
         else stride = $urandom_range(1, 3);
         if (walk_row > 32'hFFFF_FFFF - stride) stride = '0;
         walk_row = walk_row + stride;
      end
   endtask

   // receiver: changing stall patterns, plus a long hold-off on request
   initial begin : receiver
      int unsigned tick;
      rx_mode_type rx_mode;
      tick       = 0;
      rx_mode    = RX_OPEN;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_asks != stall_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
            stall_done++;
         end else begin
            if (tick % 50 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
            tick++;
            case (rx_mode)
               RX_OPEN:  rsp_tready <= 1'b1;
               RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
               RX_COMB:  rsp_tready <= (tick % 5) < 2;
               default:  rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // runaway guard
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("row_aligned_nnz_balancer test failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int          k;
      int          nruns;
      int          len;
      bit          broken;
      bit          closed;
      bit          extreme;
      bit          wrote;
      logic [31:0] data;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_typed  = 1'b0;
      req_exp    = NO_REC;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, registers only change with the block drained
      for (k = 0; k < DIR_ROWS; k++) begin
         if (dir_table[k].op == DIR_CSR) begin
            settle();
            write_reg(dir_table[k].reg_idx, dir_table[k].value);
         end else begin
            send_item(dir_table[k].value, dir_table[k].fin, dir_table[k].typed,
                      dir_table[k].rec);
         end
      end

      // random phases: new settings, then a few runs; a run may stay open
      // across the next register change
      while (useful_items < ITEM_TARGET) begin
         settle();
         phases++;
         steady_send = ($urandom_range(0, 3) == 0);
         extreme = ($urandom_range(0, 5) == 0);
         wrote   = 1'b0;
         if ($urandom_range(0, 3) != 0) begin
            data = $urandom;
            if (extreme) begin
               case ($urandom_range(0, 5))
                  0:       data[8:0] = 9'd0;
                  1:       data[8:0] = 9'd1;
                  2:       data[8:0] = 9'd255;
                  3:       data[8:0] = 9'd256;
                  4:       data[8:0] = 9'd257;
                  default: data[8:0] = 9'h1FF;
               endcase
            end else begin
               data[8:0] = 9'($urandom_range(1, 8));
            end
            write_reg(CSR_PART_COUNT, data);
            wrote = 1'b1;
         end
         if ($urandom_range(0, 3) != 0 || !wrote) begin
            if (extreme) begin
               case ($urandom_range(0, 2))
                  0:       data = '0;
                  1:       data = 32'hFFFF_FFFF;
                  default: data = $urandom;
               endcase
            end else begin
               data = $urandom_range(0, 60);
            end
            write_reg(CSR_TOTAL_NNZ, data);
         end
         if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? CSR_IDX_SPARE0 : CSR_IDX_SPARE1, $urandom);

         // back pressure: receiver holds off while a dense stream keeps coming
         if (phases == PRESSURE_PHASE) begin
            steady_send = 1'b1;
            stall_asks++;
         end
         nruns = (phases == PRESSURE_PHASE) ? 4 : $urandom_range(1, 4);
         for (k = 0; k < nruns; k++) begin
            len    = (phases == PRESSURE_PHASE) ? 40 : $urandom_range(1, 40);
            broken = (len > 1) && ($urandom_range(0, 5) == 0);
            closed = broken || (k < nruns - 1) || ($urandom_range(0, 3) != 0);
            play_run(len, closed, broken);
         end
      end

      settle();
      $display("covered %0d input transfers over %0d random phases, %0d register writes",
               items_in, phases, reg_writes);
      $display("checked %0d part records: %0d unsorted aborts, %0d run ends, %0d mismatches",
               parts_checked, abort_records, run_ends, mismatches);
      if (mismatches == 0) begin
         $display("row_aligned_nnz_balancer test passed");
      end else begin
         $display("row_aligned_nnz_balancer test failed");
      end
      $finish;
   end

endmodule
